FILE: design/assert_macros.svh
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define CLTI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: label");
// Expression that must never be true outside reset.
`define CLTI_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: label");
`else
`define CLTI_ASSERT(label, clk, rst, prop)
`define CLTI_NEVER(label, clk, rst, expr)
`endif

`endif

FILE: design/clti_pkg.sv
package clti_pkg;

  localparam int TIME_W  = 32;
  localparam int VALUE_W = 32;

  // Request kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_INTERP = 2'd0;
  localparam logic [1:0] STAT_LOW    = 2'd1;
  localparam logic [1:0] STAT_HIGH   = 2'd2;
  localparam logic [1:0] STAT_FEW    = 2'd3;

  typedef struct packed {
    logic [1:0]                kind;
    logic [TIME_W-1:0]         point_time;
    logic signed [VALUE_W-1:0] point_value;
    logic [TIME_W-1:0]         query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [1:0]                status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_READ_HI,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_MULTIPLY,
    ST_FINISH
  } state_t;

  // Table read address source
  typedef enum logic [1:0] {
    RD_MID,
    RD_LOWER,
    RD_UPPER
  } rd_sel_t;

  // Result source
  typedef enum logic [1:0] {
    RES_INTERP,
    RES_LOW,
    RES_HIGH,
    RES_FEW
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    logic     search_init;
    logic     search_step;
    rd_sel_t  rd_sel;
    logic     cap_lo;
    logic     div_load;
    logic     div_step;
    logic     mul;
    logic     load_out;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic few_points;
    logic clamp_low;
    logic clamp_high;
    logic search_done;
    logic div_last;
  } dp_status_t;

endpackage

FILE: design/clti_dp.sv
module clti_dp #(
  parameter int TABLE_DEPTH   = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  clti_pkg::in_item_t     in_data,
  input  clti_pkg::dp_cmd_t      cmd,
  output clti_pkg::dp_status_t   status,
  output clti_pkg::out_item_t    out_data
);
  import clti_pkg::*;

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int STEP_W = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;
  localparam int PROD_W = FRACTION_BITS + VALUE_W + 2;

  // Breakpoint storage
  logic [TIME_W-1:0]         time_mem  [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] value_mem [TABLE_DEPTH];
  logic [TIME_W-1:0]         rd_time;
  logic signed [VALUE_W-1:0] rd_value;

  logic [CNT_W-1:0]          point_count;
  logic [TIME_W-1:0]         first_time, last_time;
  logic signed [VALUE_W-1:0] first_value, last_value;
  logic [TIME_W-1:0]         qt;

  // Search bounds
  logic [CNT_W-1:0] lo, hi, mid, rd_addr;

  // Divide and multiply
  logic [TIME_W-1:0]           t1, div, rem;
  logic signed [VALUE_W-1:0]   v1;
  logic signed [VALUE_W:0]     diff;
  logic [FRACTION_BITS-1:0]    quot;
  logic [STEP_W-1:0]           step;
  logic signed [PROD_W-1:0]    prod, prod_shr;
  logic [TIME_W:0]             rem2;
  logic                        rem_ge;
  logic [VALUE_W-1:0]          interp_value;
  logic                        append_ok;

  assign append_ok = cmd.accept && (in_data.kind == KIND_APPEND) &&
                     (point_count < CNT_W'(TABLE_DEPTH)) &&
                     ((point_count == '0) || (in_data.point_time >= last_time));

  assign mid = lo + ((hi - lo) >> 1);

  always_comb begin
    case (cmd.rd_sel)
      RD_LOWER: rd_addr = lo - CNT_W'(1);
      RD_UPPER: rd_addr = lo;
      default:  rd_addr = mid;
    endcase
  end

  // Table write on append, registered read every cycle
  always_ff @(posedge clk) begin
    if (append_ok) begin
      time_mem[point_count[IDX_W-1:0]]  <= in_data.point_time;
      value_mem[point_count[IDX_W-1:0]] <= in_data.point_value;
    end
    rd_time  <= time_mem[rd_addr[IDX_W-1:0]];
    rd_value <= value_mem[rd_addr[IDX_W-1:0]];
  end

  // Point count, end points and latched query time
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cmd.accept && (in_data.kind == KIND_CLEAR)) begin
      point_count <= '0;
    end else if (append_ok) begin
      point_count <= point_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (append_ok) begin
      if (point_count == '0) begin
        first_time  <= in_data.point_time;
        first_value <= in_data.point_value;
      end
      last_time  <= in_data.point_time;
      last_value <= in_data.point_value;
    end
    if (cmd.accept) begin
      qt <= in_data.query_time;
    end
  end

  // Binary search for the first point with a greater time
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo <= '0;
      hi <= point_count;
    end else if (cmd.search_step) begin
      if (rd_time <= qt) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign rem2   = {rem, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, div});

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      t1 <= rd_time;
      v1 <= rd_value;
    end
    if (cmd.div_load) begin
      rem  <= qt - t1;
      div  <= rd_time - t1;
      diff <= $signed({rd_value[VALUE_W-1], rd_value}) - $signed({v1[VALUE_W-1], v1});
      quot <= '0;
      step <= STEP_W'(FRACTION_BITS - 1);
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? TIME_W'(rem2 - {1'b0, div}) : rem2[TIME_W-1:0];
      quot <= {quot[FRACTION_BITS-2:0], rem_ge};
      step <= step - STEP_W'(1);
    end
    if (cmd.mul) begin
      prod <= $signed({1'b0, quot}) * diff;
    end
  end

  // Floor of the scaled product, added to the lower value
  assign prod_shr     = prod >>> FRACTION_BITS;
  assign interp_value = v1 + prod_shr[VALUE_W-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.res_sel)
        RES_FEW: begin
          out_data.result_value <= '0;
          out_data.status       <= STAT_FEW;
        end
        RES_LOW: begin
          out_data.result_value <= first_value;
          out_data.status       <= STAT_LOW;
        end
        RES_HIGH: begin
          out_data.result_value <= last_value;
          out_data.status       <= STAT_HIGH;
        end
        default: begin
          out_data.result_value <= interp_value;
          out_data.status       <= STAT_INTERP;
        end
      endcase
    end
  end

  assign status.few_points  = (point_count < CNT_W'(2));
  assign status.clamp_low   = (qt <= first_time);
  assign status.clamp_high  = (qt >= last_time);
  assign status.search_done = (lo >= hi);
  assign status.div_last    = (step == '0);

endmodule

FILE: design/clti_ctrl.sv
module clti_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  clti_pkg::dp_status_t status,
  output clti_pkg::dp_cmd_t    cmd
);
  import clti_pkg::*;

  state_t   state, state_next;
  res_sel_t res_sel, res_sel_next;

  // State and result source registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      res_sel <= RES_FEW;
    end else begin
      state   <= state_next;
      res_sel <= res_sel_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    res_sel_next = res_sel;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_sel   = RD_MID;
    cmd.res_sel  = res_sel;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && (in_kind == KIND_QUERY)) begin
          state_next = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (status.few_points) begin
          res_sel_next = RES_FEW;
          state_next   = ST_FINISH;
        end else if (status.clamp_low) begin
          res_sel_next = RES_LOW;
          state_next   = ST_FINISH;
        end else if (status.clamp_high) begin
          res_sel_next = RES_HIGH;
          state_next   = ST_FINISH;
        end else begin
          res_sel_next    = RES_INTERP;
          cmd.search_init = 1'b1;
          state_next      = ST_SEARCH_RD;
        end
      end
      ST_SEARCH_RD: begin
        if (status.search_done) begin
          cmd.rd_sel = RD_LOWER;
          state_next = ST_READ_HI;
        end else begin
          cmd.rd_sel = RD_MID;
          state_next = ST_SEARCH_CMP;
        end
      end
      ST_SEARCH_CMP: begin
        cmd.search_step = 1'b1;
        state_next      = ST_SEARCH_RD;
      end
      ST_READ_HI: begin
        cmd.rd_sel = RD_UPPER;
        cmd.cap_lo = 1'b1;
        state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_MULTIPLY;
        end
      end
      ST_MULTIPLY: begin
        cmd.mul    = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/clamped_linear_table_interpolator_top.sv
// Append and clear requests leave in_ready high.
// A query that is clamped or meets a table of fewer than two points goes straight to
// the output; otherwise it runs the binary search over the single-port table read and
// the one-bit-per-cycle divider. One request is in flight at a time.
// Synchronous active-high reset empties the table; table contents are not cleared.
`include "assert_macros.svh"

module clamped_linear_table_interpolator_top #(
  parameter int TABLE_DEPTH   = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  clti_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clti_pkg::out_item_t out_data
);
  import clti_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  clti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  clti_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  // A result is never loaded in the cycle a request is taken
  `CLTI_NEVER(a_no_load_on_accept, clk, rst, cmd.load_out && in_valid && in_ready)
  // Datapath steps are mutually exclusive
  `CLTI_ASSERT(a_steps_exclusive, clk, rst, $onehot0({cmd.search_step, cmd.div_step, cmd.mul, cmd.load_out}))
  // A query holds off the next request
  `CLTI_ASSERT(a_query_busy, clk, rst, (in_valid && in_ready && in_data.kind == KIND_QUERY) |=> !in_ready)
  // A result appears only after a load
  `CLTI_ASSERT(a_out_from_load, clk, rst, $rose(out_valid) |-> $past(cmd.load_out))

endmodule

FILE: tb/sv/clamped_linear_table_interpolator_top_tb.sv
`timescale 1ns / 100ps

module clamped_linear_table_interpolator_top_tb;
  import clti_pkg::*;

  localparam int TBL_DEPTH = 256;
  localparam int FRAC_BITS = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 112;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Stimulus control
  in_item_t request_backlog[$];
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       hold_req = 0;
  int       hold_ack = 0;
  int       hold_left = 0;
  int       items_queued = 0;

  // Mirror of the breakpoint table
  logic [31:0]        tbl_time[TBL_DEPTH];
  logic signed [31:0] tbl_value[TBL_DEPTH];
  int unsigned        tbl_count = 0;
  out_item_t          owed_lookups[$];

  // Bookkeeping
  int mismatch_count = 0;
  int req_accepted = 0;
  int status_seen[4] = '{default: 0};
  int idle_cycles = 0;

  clamped_linear_table_interpolator_top #(
    .TABLE_DEPTH  (TBL_DEPTH),
    .FRACTION_BITS(FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Apply one request to the table mirror; returns 1 when it yields a lookup result
  function automatic bit table_apply(input in_item_t req, output out_item_t res);
    int unsigned lo, hi, mid, last, i2;
    logic [31:0] t1, t2;
    logic [63:0] frac;
    longint      v1, v2, prod, sum;
    res = '0;
    if (req.kind == KIND_CLEAR) begin
      tbl_count = 0;
      return 1'b0;
    end
    if (req.kind == KIND_APPEND) begin
      // full table or a time below the last one: dropped
      if (tbl_count < TBL_DEPTH &&
          (tbl_count == 0 || req.point_time >= tbl_time[tbl_count - 1])) begin
        tbl_time[tbl_count] = req.point_time;
        tbl_value[tbl_count] = req.point_value;
        tbl_count++;
      end
      return 1'b0;
    end
    if (req.kind != KIND_QUERY) return 1'b0;

    if (tbl_count < 2) begin
      res.status = STAT_FEW;
      return 1'b1;
    end
    last = tbl_count - 1;
    if (req.query_time <= tbl_time[0]) begin
      res.result_value = tbl_value[0];
      res.status = STAT_LOW;
      return 1'b1;
    end
    if (req.query_time >= tbl_time[last]) begin
      res.result_value = tbl_value[last];
      res.status = STAT_HIGH;
      return 1'b1;
    end

    // first breakpoint with a later time
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_time[mid] <= req.query_time) lo = mid + 1;
      else hi = mid;
    end
    i2 = lo;
    if (i2 < 1) i2 = 1;
    if (i2 > last) i2 = last;
    t1 = tbl_time[i2 - 1];
    t2 = tbl_time[i2];
    v1 = tbl_value[i2 - 1];
    v2 = tbl_value[i2];
    if (t2 <= t1 || req.query_time < t1) frac = '0;
    else frac = ({32'd0, req.query_time - t1} << FRAC_BITS) / {32'd0, t2 - t1};
    // arithmetic shift of the exact product is a floor
    prod = $signed(frac) * (v2 - v1);
    sum = v1 + (prod >>> FRAC_BITS);
    res.result_value = sum[31:0];
    res.status = STAT_INTERP;
    return 1'b1;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= request_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: check results, track accepted requests, watchdog
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = out_data;
        status_seen[got.status]++;
        if (owed_lookups.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, got value %h status %0d",
                   $time, got.result_value, got.status);
        end else begin
          want = owed_lookups.pop_front();
          if (got.result_value !== want.result_value) begin
            mismatch_count++;
            $display("%0t: result_value mismatch: expected %h, got %h",
                     $time, want.result_value, got.result_value);
          end
          if (got.status !== want.status) begin
            mismatch_count++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, got.status);
          end
        end
      end
      if (in_valid && in_ready) begin
        req_accepted++;
        if (table_apply(in_data, want)) owed_lookups = {owed_lookups, want};
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results still owed", $time,
                 owed_lookups.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic push_req(input logic [1:0] kind, input logic [31:0] pt, pv, qt);
    in_item_t r;
    r.kind = kind;
    r.point_time = pt;
    r.point_value = pv;
    r.query_time = qt;
    request_backlog = {request_backlog, r};
    if (kind != KIND_UNUSED) items_queued++;
  endtask

  // Wait until every request is taken and every result is back, then settle
  task automatic drain();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_valid || owed_lookups.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Clear, then non-decreasing appends interleaved with queries, plus some noise
  task automatic queue_session(input int n_points, input int n_queries);
    logic [31:0] times[$];
    logic [63:0] cursor, room, step, span;
    logic [31:0] v, qt, lo_t, hi_t;
    int          p_left, q_left;
    push_req(KIND_CLEAR, $urandom, $urandom, $urandom);
    cursor = {32'd0, $urandom >> $urandom_range(0, 31)};
    v = $urandom;
    p_left = n_points;
    q_left = n_queries;
    while (p_left > 0 || q_left > 0) begin
      if ($urandom_range(0, 24) == 0)
        push_req(KIND_UNUSED, $urandom, $urandom, $urandom);
      if (p_left > 0 && $urandom_range(0, p_left + q_left - 1) < p_left) begin
        room = (64'hFFFF_FFFF - cursor) / p_left;
        case ($urandom_range(0, 7))
          0: step = '0;
          1: step = $urandom_range(1, 16);
          default: step = ({$urandom, $urandom} % (room + 64'd1)) >> $urandom_range(0, 20);
        endcase
        if (step > room) step = room;
        cursor = cursor + step;
        case ($urandom_range(0, 7))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = v + $urandom_range(0, 255) - 128;
          default: v = $urandom;
        endcase
        push_req(KIND_APPEND, cursor[31:0], v, $urandom);
        times = {times, cursor[31:0]};
        p_left--;
        // out-of-order append, must be dropped
        if (cursor != 0 && $urandom_range(0, 11) == 0)
          push_req(KIND_APPEND, $urandom_range(0, cursor[31:0] - 1), $urandom, $urandom);
      end else begin
        qt = $urandom;
        if (times.size() > 0) begin
          lo_t = times[0];
          hi_t = times[times.size() - 1];
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              span = {32'd0, hi_t} - {32'd0, lo_t} + 64'd1;
              qt = lo_t + 32'({$urandom, $urandom} % span);
            end
            4, 5: qt = times[$urandom_range(0, times.size() - 1)];
            6: qt = lo_t & $urandom;
            7: qt = hi_t | $urandom;
            default: ;
          endcase
        end
        push_req(KIND_QUERY, $urandom, $urandom, qt);
        q_left--;
      end
    end
  endtask

  initial begin
    int target;
    int n_pts;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: table edges, clamps, dropped appends, unused kind
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'h0);                  // empty table
    push_req(KIND_APPEND, 32'h0, 32'h8000_0000, 32'h0);
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'hFFFF_FFFF);          // one point
    push_req(KIND_APPEND, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0);
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'h0);                  // at first time
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'h0001_0000);          // at last time
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'h0000_8000);          // full value swing
    push_req(KIND_APPEND, 32'h0000_5000, 32'h1234_5678, 32'h0); // out of order
    push_req(KIND_APPEND, 32'h0001_0000, 32'h0, 32'h0);         // repeated time
    push_req(KIND_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'hFFFF_FFFE);
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'h0000_FFFF);
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'h0001_0000);          // on the repeated time
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'hFFFF_FFFF);
    push_req(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'h0002_0000);
    push_req(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_1234);
    push_req(KIND_APPEND, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    push_req(KIND_APPEND, 32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFF);
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'hFFFF_FFFF);          // all times equal
    push_req(KIND_QUERY, 32'h0, 32'h0, 32'h0);
    push_req(KIND_CLEAR, 32'h0, 32'h0, 32'h0);
    drain();

    // Receiver holds off while the driver keeps offering requests
    hold_req++;
    queue_session(6, 12);
    drain();

    // Fill the table and overflow it
    queue_session(TBL_DEPTH + 3, 40);
    drain();

    // Random sessions under each idle/stall mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) begin
        n_pts = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 20);
        queue_session(n_pts, $urandom_range(4, 14));
        if ($urandom_range(0, 2) == 0) drain();
      end
      drain();
    end

    $display("Summary: %0d requests taken; lookups interpolated %0d, low %0d, high %0d, short %0d",
             req_accepted, status_seen[STAT_INTERP], status_seen[STAT_LOW],
             status_seen[STAT_HIGH], status_seen[STAT_FEW]);
    $display("Covered a full %0d-entry table, dropped appends, and idle/stall mixes",
             TBL_DEPTH);
    if (mismatch_count == 0 && owed_lookups.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
